FILE: rtl/core/afr_pkg.sv
// Shared types and constants for the adaptive window frame rate meter.
package afr_pkg;

  localparam int MAX_FRAMES = 256;
  localparam int RING_AW    = $clog2(MAX_FRAMES);
  localparam int CNT_W      = RING_AW + 1;
  localparam int DUR_W      = 32;
  localparam int SUM_W      = DUR_W + RING_AW;
  localparam int CFG_W      = 26;
  localparam int RATE_W     = 24;
  localparam int SCALE_W    = 28;
  localparam int DVD_W      = CNT_W + SCALE_W;
  localparam int DIV_CW     = $clog2(DVD_W + 1);
  localparam int MIN_KEEP   = 4;

  localparam logic [SCALE_W-1:0] RATE_SCALE  = SCALE_W'(256000000);
  localparam logic [RATE_W-1:0]  RATE_MAX    = '1;
  localparam logic [CFG_W-1:0]   TARGET_RST  = CFG_W'(1000000);
  localparam logic [CFG_W-1:0]   SLACK_RST   = CFG_W'(1000000);

  localparam logic EV_FRAME = 1'b0;
  localparam logic EV_STOP  = 1'b1;

  localparam logic REG_TARGET = 1'b0;
  localparam logic REG_SLACK  = 1'b1;

  typedef struct packed {
    logic             event_kind;
    logic [DUR_W-1:0] timestamp_us;
  } in_item_t;

  typedef struct packed {
    logic [RATE_W-1:0] frame_rate;
    logic [CNT_W-1:0]  window_count;
    logic              rate_updated;
  } out_item_t;

endpackage

FILE: rtl/core/adaptive_window_frame_rate_meter.sv
// Top level of the adaptive window frame rate meter.
//
// Input channel (in_valid, in_stall, in_data) takes one event per transaction:
// a rendered frame or stop timing, with a microsecond timestamp. Every event
// yields exactly one result transaction on (out_valid, out_stall, out_data):
// the held rate (UQ16.8 frames per second), the window count and whether the
// rate was recomputed. Config writes (cfg_valid, cfg_ready, cfg_index,
// cfg_data) set the window target and slack; cfg_ready is always high.
// Frame durations live in a 256-entry RAM with registered read data.
// One event is processed at a time; in_stall is high while it is in work.
// Stop and first-frame events go straight to the done state, which loads the
// output register. A timed frame first updates the window sum, runs the
// bit-serial divider (skipped when the window sum is zero), then the grow and
// shrink steps and the index update, and then loads it. The next event is
// taken the cycle after the result is loaded.
// A result stalled at the output holds the block until it is taken.
// Reset (rst, synchronous) empties the window to one zero entry, clears the
// rate and restores both config registers to 1000000 us.
module adaptive_window_frame_rate_meter (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  afr_pkg::in_item_t      in_data,
  output logic                   out_valid,
  input  logic                   out_stall,
  output afr_pkg::out_item_t     out_data,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic                   cfg_index,
  input  logic [afr_pkg::CFG_W-1:0] cfg_data
);
  import afr_pkg::*;

  typedef enum logic [12:0] {
    ST_IDLE = 13'b0000000000001,
    ST_CUR  = 13'b0000000000010,
    ST_DIV  = 13'b0000000000100,
    ST_GRW  = 13'b0000000001000,
    ST_GSUM = 13'b0000000010000,
    ST_GSH  = 13'b0000000100000,
    ST_GDR  = 13'b0000001000000,
    ST_SHK  = 13'b0000010000000,
    ST_SSUB = 13'b0000100000000,
    ST_SSH  = 13'b0001000000000,
    ST_SDR  = 13'b0010000000000,
    ST_FIN  = 13'b0100000000000,
    ST_DONE = 13'b1000000000000
  } state_t;

  state_t              state;
  logic [CFG_W-1:0]    target;
  logic [CFG_W-1:0]    slack;
  logic [CNT_W-1:0]    n;
  logic [RING_AW-1:0]  idx;
  logic [SUM_W-1:0]    sum;
  logic [DUR_W-1:0]    last_time;
  logic                ltv;
  logic [RATE_W-1:0]   rate;
  logic                upd;
  logic                e0v;
  logic [DUR_W-1:0]    delta;
  logic                wrap;
  logic [CNT_W-1:0]    k;
  logic [RING_AW-1:0]  wa;
  logic                wv;
  logic                rz;
  logic [SUM_W-1:0]    rem;
  logic [DVD_W-1:0]    dvd;
  logic [DIV_CW-1:0]   dcnt;

  logic                we;
  logic [RING_AW-1:0]  waddr;
  logic [DUR_W-1:0]    wdata;
  logic [RING_AW-1:0]  raddr;
  logic [DUR_W-1:0]    rdata;
  logic [DUR_W-1:0]    rdval;
  logic [SUM_W-1:0]    sum_cur;
  logic [SUM_W:0]      r2;
  logic                ge;
  logic [CNT_W-1:0]    idx_p1;
  logic [CNT_W-1:0]    idx_p2;
  logic                at_end;
  logic                grow;
  logic                shrink;
  logic [CFG_W:0]      limit;
  logic                out_free;

  afr_ram #(.WIDTH(DUR_W), .DEPTH(MAX_FRAMES)) u_ring (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign in_stall  = (state != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || !out_stall;

  assign rdval   = rz ? '0 : rdata;
  assign sum_cur = sum - {{RING_AW{1'b0}}, rdval} + {{RING_AW{1'b0}}, delta};
  assign r2      = {rem, dvd[DVD_W-1]};
  assign ge      = (r2 >= {1'b0, sum});
  assign idx_p1  = {1'b0, idx} + CNT_W'(1);
  assign idx_p2  = {1'b0, idx} + CNT_W'(2);
  assign at_end  = (idx_p1 >= n);
  assign limit   = {1'b0, target} + {1'b0, slack};
  assign grow    = (sum < {{(SUM_W-CFG_W){1'b0}}, target}) && (n != CNT_W'(MAX_FRAMES));
  assign shrink  = (sum > {{(SUM_W-CFG_W-1){1'b0}}, limit}) && (n > CNT_W'(MIN_KEEP));

  always_comb begin
    we    = wv;
    waddr = wa;
    wdata = rdval;
    raddr = idx;
    case (state)
      ST_CUR: begin
        we    = 1'b1;
        waddr = idx;
        wdata = delta;
      end
      ST_GRW, ST_SHK: begin
        raddr = at_end ? '0 : idx_p1[RING_AW-1:0];
      end
      ST_GSUM: begin
        we    = wrap;
        waddr = idx_p1[RING_AW-1:0];
        wdata = rdval;
      end
      ST_GSH: begin
        raddr = RING_AW'(k - CNT_W'(1));
      end
      ST_SSH: begin
        raddr = RING_AW'(k + CNT_W'(1));
      end
      default: begin
        raddr = idx;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    rz <= (raddr == '0) && !e0v;
    wv <= (state == ST_GSH) || (state == ST_SSH);
    if (rst) begin
      state     <= ST_IDLE;
      target    <= TARGET_RST;
      slack     <= SLACK_RST;
      n         <= CNT_W'(1);
      idx       <= '0;
      sum       <= '0;
      last_time <= '0;
      ltv       <= 1'b0;
      rate      <= '0;
      upd       <= 1'b0;
      e0v       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (we && waddr == '0) begin
        e0v <= 1'b1;
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_TARGET) begin
          target <= cfg_data;
        end else begin
          slack <= cfg_data;
        end
      end
      out_valid <= ((state == ST_DONE) && out_free) || (out_valid && out_stall);
      case (state)
        ST_IDLE: begin
          if (in_valid && !in_stall) begin
            upd <= 1'b0;
            if (in_data.event_kind == EV_STOP) begin
              ltv   <= 1'b0;
              state <= ST_DONE;
            end else if (!ltv) begin
              ltv       <= 1'b1;
              last_time <= in_data.timestamp_us;
              state     <= ST_DONE;
            end else begin
              delta     <= in_data.timestamp_us - last_time;
              last_time <= in_data.timestamp_us;
              state     <= ST_CUR;
            end
          end
        end
        ST_CUR: begin
          sum <= sum_cur;
          if (sum_cur != '0) begin
            rem   <= '0;
            dvd   <= DVD_W'(n) * DVD_W'(RATE_SCALE);
            dcnt  <= '0;
            state <= ST_DIV;
          end else begin
            state <= ST_GRW;
          end
        end
        ST_DIV: begin
          if (dcnt == DIV_CW'(DVD_W)) begin
            rate  <= (|dvd[DVD_W-1:RATE_W]) ? RATE_MAX : dvd[RATE_W-1:0];
            upd   <= 1'b1;
            state <= ST_GRW;
          end else begin
            rem  <= ge ? SUM_W'(r2 - {1'b0, sum}) : r2[SUM_W-1:0];
            dvd  <= {dvd[DVD_W-2:0], ge};
            dcnt <= dcnt + DIV_CW'(1);
          end
        end
        ST_GRW: begin
          wrap  <= at_end;
          state <= grow ? ST_GSUM : ST_SHK;
        end
        ST_GSUM: begin
          sum <= sum + {{RING_AW{1'b0}}, rdval};
          n   <= n + CNT_W'(1);
          k   <= n;
          state <= wrap ? ST_SHK : ST_GSH;
        end
        ST_GSH: begin
          wa <= k[RING_AW-1:0];
          if (k == idx_p2) begin
            state <= ST_GDR;
          end else begin
            k <= k - CNT_W'(1);
          end
        end
        ST_GDR: begin
          state <= ST_SHK;
        end
        ST_SHK: begin
          wrap  <= at_end;
          state <= shrink ? ST_SSUB : ST_FIN;
        end
        ST_SSUB: begin
          sum <= sum - {{RING_AW{1'b0}}, rdval};
          n   <= n - CNT_W'(1);
          k   <= wrap ? '0 : idx_p1;
          state <= (wrap || idx_p2 < n) ? ST_SSH : ST_FIN;
        end
        ST_SSH: begin
          wa <= k[RING_AW-1:0];
          if (k == n - CNT_W'(1)) begin
            state <= ST_SDR;
          end else begin
            k <= k + CNT_W'(1);
          end
        end
        ST_SDR: begin
          state <= ST_FIN;
        end
        ST_FIN: begin
          idx   <= at_end ? RING_AW'(idx_p1 - n) : idx_p1[RING_AW-1:0];
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (out_free) begin
            out_data.frame_rate   <= rate;
            out_data.window_count <= n;
            out_data.rate_updated <= upd;
            state                 <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: rtl/core/afr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module afr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
